// File: rtl/core/periodic_interrupt_timer_macros.svh
// Assertion macros used by the periodic interrupt timer top level.
`ifndef PERIODIC_INTERRUPT_TIMER_MACROS_SVH
`define PERIODIC_INTERRUPT_TIMER_MACROS_SVH

`ifndef SYNTHESIS
`define PIT_ASSERT(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("pit assertion failed");
`define PIT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pit assertion failed");
`define PIT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pit assertion failed");
`else
`define PIT_ASSERT(label, clk, rst_n, cond)
`define PIT_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define PIT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/core/pit_pkg.sv
// Types and constants shared by the periodic interrupt timer modules.
`default_nettype none

package pit_pkg;

    localparam int OUT_CHANNELS = 4;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    localparam logic [2:0] SEL_LOAD   = 3'd0;
    localparam logic [2:0] SEL_COUNT  = 3'd1;
    localparam logic [2:0] SEL_CTRL   = 3'd2;
    localparam logic [2:0] SEL_FLAG   = 3'd3;
    localparam logic [2:0] SEL_MODULE = 3'd4;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [1:0]  channel;
        logic [2:0]  reg_select;
        logic [31:0] write_data;
    } t_in_item;

    typedef struct packed {
        logic [31:0] read_data;
        logic [3:0]  irq_lines;
        logic [3:0]  flag_bits;
    } t_out_item;

    typedef struct packed {
        logic tick;
        logic wr_load;
        logic wr_ctrl;
        logic clr_flag;
    } t_ch_cmd;

    typedef struct packed {
        logic enable;
        logic irq_en;
        logic flag;
        logic n_irq_en;
        logic n_flag;
    } t_ch_stat;

endpackage

`default_nettype wire

// File: rtl/core/pit_channel.sv
// One timer channel: load value, down counter, control bits and timeout flag.
`default_nettype none

module pit_channel
    import pit_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_apply,
    input  wire t_ch_cmd                i_cmd,
    input  wire logic [31:0]            i_data,
    output logic [COUNT_WIDTH-1:0]      o_load,
    output logic [COUNT_WIDTH-1:0]      o_count,
    output t_ch_stat                    o_stat
);

    logic [COUNT_WIDTH-1:0] r_load, n_load;
    logic [COUNT_WIDTH-1:0] r_count, n_count;
    logic                   r_enable, n_enable;
    logic                   r_irq_en, n_irq_en;
    logic                   r_flag, n_flag;

    always_comb begin
        n_load   = r_load;
        n_count  = r_count;
        n_enable = r_enable;
        n_irq_en = r_irq_en;
        n_flag   = r_flag;
        if (i_apply) begin
            if (i_cmd.tick && r_enable) begin
                if (r_count == '0) begin
                    n_count = r_load;
                    n_flag  = 1'b1;
                end else begin
                    n_count = r_count - COUNT_WIDTH'(1);
                end
            end
            if (i_cmd.wr_load) begin
                n_load = i_data[COUNT_WIDTH-1:0];
            end
            if (i_cmd.wr_ctrl) begin
                if (i_data[0] && !r_enable) begin
                    n_count = r_load;
                end
                n_enable = i_data[0];
                n_irq_en = i_data[1];
            end
            if (i_cmd.clr_flag && i_data[0]) begin
                n_flag = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load   <= '0;
            r_count  <= '0;
            r_enable <= 1'b0;
            r_irq_en <= 1'b0;
            r_flag   <= 1'b0;
        end else begin
            r_load   <= n_load;
            r_count  <= n_count;
            r_enable <= n_enable;
            r_irq_en <= n_irq_en;
            r_flag   <= n_flag;
        end
    end

    assign o_load          = r_load;
    assign o_count         = r_count;
    assign o_stat.enable   = r_enable;
    assign o_stat.irq_en   = r_irq_en;
    assign o_stat.flag     = r_flag;
    assign o_stat.n_irq_en = n_irq_en;
    assign o_stat.n_flag   = n_flag;

endmodule

`default_nettype wire

// File: rtl/core/periodic_interrupt_timer.sv
// Top level of the multi-channel periodic interrupt timer with its register bank.
//
// Channel | Direction | Payload    | Handshake
// in      | input     | t_in_item  | i_in_valid / o_in_stall
// out     | output    | t_out_item | o_out_valid / i_out_stall
//
// One transaction is taken every cycle unless the input channel stalls; each result is registered.
// The input register feeds the channel update and read mux, which load the result register.
// Reset holds all channels stopped with zero registers and the module disabled.
// A stall on the output holds the result register and, once the input register is
// also full, stalls the input channel.
`default_nettype none
`include "periodic_interrupt_timer_macros.svh"

module periodic_interrupt_timer
    import pit_pkg::*;
#(
    parameter int NUM_CHANNELS = 4,
    parameter int COUNT_WIDTH  = 32
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_item  i_in_item,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out_item
);

    localparam int OUT_N = (NUM_CHANNELS < OUT_CHANNELS) ? NUM_CHANNELS : OUT_CHANNELS;

    logic       r_in_valid;
    t_in_item   r_in;
    logic       r_out_valid;
    t_out_item  r_out, n_out;
    logic       r_mod_disable, n_mod_disable;
    logic       advance, take_in, proc, mod_wr;

    logic [COUNT_WIDTH-1:0] ch_load  [NUM_CHANNELS];
    logic [COUNT_WIDTH-1:0] ch_count [NUM_CHANNELS];
    t_ch_stat               ch_stat  [NUM_CHANNELS];
    t_ch_cmd                ch_cmd   [NUM_CHANNELS];
    logic [3:0]             n_irq, n_flags;

    assign advance    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !advance;
    assign take_in    = i_in_valid && !o_in_stall;
    assign proc       = r_in_valid && advance;
    assign mod_wr     = proc && (r_in.opcode == OP_WRITE) && (r_in.reg_select == SEL_MODULE);

    for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_ch
        logic hit;
        assign hit = (int'(r_in.channel) == c);
        assign ch_cmd[c].tick     = (r_in.opcode == OP_TICK) && !r_mod_disable;
        assign ch_cmd[c].wr_load  = (r_in.opcode == OP_WRITE) && hit
                                    && (r_in.reg_select == SEL_LOAD);
        assign ch_cmd[c].wr_ctrl  = (r_in.opcode == OP_WRITE) && hit
                                    && (r_in.reg_select == SEL_CTRL);
        assign ch_cmd[c].clr_flag = (r_in.opcode == OP_WRITE) && hit
                                    && (r_in.reg_select == SEL_FLAG);

        pit_channel #(
            .COUNT_WIDTH (COUNT_WIDTH)
        ) u_channel (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_apply (proc),
            .i_cmd   (ch_cmd[c]),
            .i_data  (r_in.write_data),
            .o_load  (ch_load[c]),
            .o_count (ch_count[c]),
            .o_stat  (ch_stat[c])
        );
    end

    for (genvar c = 0; c < OUT_CHANNELS; c++) begin : g_out
        if (c < OUT_N) begin : g_live
            assign n_flags[c] = ch_stat[c].n_flag;
            assign n_irq[c]   = ch_stat[c].n_flag && ch_stat[c].n_irq_en;
        end else begin : g_absent
            assign n_flags[c] = 1'b0;
            assign n_irq[c]   = 1'b0;
        end
    end

    always_comb begin
        n_mod_disable = r_mod_disable;
        if (mod_wr) begin
            n_mod_disable = r_in.write_data[1];
        end
    end

    always_comb begin
        n_out           = '0;
        n_out.irq_lines = n_irq;
        n_out.flag_bits = n_flags;
        if (r_in.opcode == OP_READ) begin
            if (r_in.reg_select == SEL_MODULE) begin
                n_out.read_data = {30'd0, r_mod_disable, 1'b0};
            end else begin
                for (int c = 0; c < NUM_CHANNELS; c++) begin
                    if (int'(r_in.channel) == c) begin
                        case (r_in.reg_select)
                            SEL_LOAD:  n_out.read_data = 32'(ch_load[c]);
                            SEL_COUNT: n_out.read_data = 32'(ch_count[c]);
                            SEL_CTRL:  n_out.read_data = {30'd0, ch_stat[c].irq_en,
                                                          ch_stat[c].enable};
                            SEL_FLAG:  n_out.read_data = {31'd0, ch_stat[c].flag};
                            default:   n_out.read_data = '0;
                        endcase
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_mod_disable <= 1'b1;
        end else begin
            r_mod_disable <= n_mod_disable;
            if (take_in) begin
                r_in_valid <= 1'b1;
            end else if (proc) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= proc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_in <= i_in_item;
        end
        if (proc) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    `PIT_ASSERT_IMPL(a_irq_flag, i_clk, i_rst_n, r_out_valid, ~|(r_out.irq_lines & ~r_out.flag_bits))
    `PIT_ASSERT_IMPL(a_stall_cause, i_clk, i_rst_n, o_in_stall, r_out_valid && i_out_stall)
    `PIT_ASSERT_IMPL(a_mod_change, i_clk, i_rst_n, n_mod_disable != r_mod_disable, mod_wr)
    `PIT_ASSERT_NEXT(a_proc_fills_out, i_clk, i_rst_n, proc, r_out_valid)

endmodule

`default_nettype wire

// File: verif/testbench.sv
// Self-checking testbench for the periodic interrupt timer, checking each result against a predictor.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pit_pkg::*;

    localparam int NUM_CH         = 4;
    localparam int CNT_W          = 32;
    localparam int RANDOM_ITEMS   = 1800;
    localparam int MAX_REPORTS    = 10;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int TAIL_CYCLES    = 20;

    localparam logic [1:0] OP_NONE     = 2'd3;
    localparam logic [2:0] SEL_SPARE_LO = 3'd5;
    localparam logic [2:0] SEL_SPARE_HI = 3'd7;

    localparam int CTRL_EN_BIT  = 0;
    localparam int CTRL_IRQ_BIT = 1;
    localparam int FLAG_CLR_BIT = 0;
    localparam int MOD_DIS_BIT  = 1;

    typedef struct {
        t_in_item item;
        bit       hold;
    } t_access;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_mode;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_item   = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_item;

    logic [CNT_W-1:0] chan_load   [NUM_CH];
    logic [CNT_W-1:0] chan_count  [NUM_CH];
    logic             chan_enable [NUM_CH];
    logic             chan_irq_en [NUM_CH];
    logic             chan_flag   [NUM_CH];
    logic             module_off;

    t_access   queued_accesses[$];
    t_out_item pending_timer_results[$];

    int sent_count  = 0;
    int recv_count  = 0;
    int error_count = 0;
    int gap_left    = 0;
    int burst_left  = 0;

    periodic_interrupt_timer #(
        .NUM_CHANNELS(NUM_CH),
        .COUNT_WIDTH (CNT_W)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item (o_out_item)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_out_item predict_timer_step(input t_in_item acc);
        t_out_item res;
        res = '0;
        case (acc.opcode)
            OP_TICK: begin
                if (!module_off) begin
                    for (int c = 0; c < NUM_CH; c++) begin
                        if (chan_enable[c]) begin
                            if (chan_count[c] == '0) begin
                                chan_count[c] = chan_load[c];
                                chan_flag[c]  = 1'b1;
                            end else begin
                                chan_count[c] = chan_count[c] - 1'b1;
                            end
                        end
                    end
                end
            end
            OP_READ: begin
                if (acc.reg_select == SEL_MODULE) begin
                    res.read_data[MOD_DIS_BIT] = module_off;
                end else if (acc.channel < NUM_CH) begin
                    case (acc.reg_select)
                        SEL_LOAD:  res.read_data = 32'(chan_load[acc.channel]);
                        SEL_COUNT: res.read_data = 32'(chan_count[acc.channel]);
                        SEL_CTRL: begin
                            res.read_data[CTRL_EN_BIT]  = chan_enable[acc.channel];
                            res.read_data[CTRL_IRQ_BIT] = chan_irq_en[acc.channel];
                        end
                        SEL_FLAG:  res.read_data[0] = chan_flag[acc.channel];
                        default: ;
                    endcase
                end
            end
            OP_WRITE: begin
                if (acc.reg_select == SEL_MODULE) begin
                    module_off = acc.write_data[MOD_DIS_BIT];
                end else if (acc.channel < NUM_CH) begin
                    case (acc.reg_select)
                        SEL_LOAD: chan_load[acc.channel] = acc.write_data[CNT_W-1:0];
                        SEL_CTRL: begin
                            if (acc.write_data[CTRL_EN_BIT] && !chan_enable[acc.channel]) begin
                                chan_count[acc.channel] = chan_load[acc.channel];
                            end
                            chan_enable[acc.channel] = acc.write_data[CTRL_EN_BIT];
                            chan_irq_en[acc.channel] = acc.write_data[CTRL_IRQ_BIT];
                        end
                        SEL_FLAG: begin
                            if (acc.write_data[FLAG_CLR_BIT]) begin
                                chan_flag[acc.channel] = 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
        for (int c = 0; c < OUT_CHANNELS && c < NUM_CH; c++) begin
            res.flag_bits[c] = chan_flag[c];
            res.irq_lines[c] = chan_flag[c] & chan_irq_en[c];
        end
        return res;
    endfunction

    task automatic queue_access(input logic [1:0] op, input logic [1:0] ch,
                                input logic [2:0] sel, input logic [31:0] data,
                                input bit hold);
        t_access acc;
        acc.item.opcode     = op;
        acc.item.channel    = ch;
        acc.item.reg_select = sel;
        acc.item.write_data = data;
        acc.hold            = hold;
        queued_accesses.push_back(acc);
    endtask

    task automatic queue_noise(input bit hold);
        queue_access(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                     3'($urandom_range(0, 7)), $urandom, hold);
    endtask

    task automatic queue_timer_sequence();
        logic [1:0]  ch;
        logic [31:0] data;
        int          n_ticks;
        bit          hold;
        ch   = 2'($urandom_range(0, 3));
        hold = ($urandom_range(0, 24) == 0);
        data = $urandom;
        data[MOD_DIS_BIT] = ($urandom_range(0, 9) == 0);
        queue_access(OP_WRITE, 2'($urandom_range(0, 3)), SEL_MODULE, data, hold);
        case ($urandom_range(0, 4))
            0:       data = $urandom;
            1:       data = 32'($urandom_range(8, 40));
            default: data = 32'($urandom_range(0, 7));
        endcase
        queue_access(OP_WRITE, ch, SEL_LOAD, data, 1'b0);
        if ($urandom_range(0, 2) == 0) begin
            data = $urandom;
            data[CTRL_EN_BIT] = 1'b0;
            queue_access(OP_WRITE, ch, SEL_CTRL, data, 1'b0);
        end
        data = $urandom;
        data[CTRL_EN_BIT] = ($urandom_range(0, 4) != 0);
        queue_access(OP_WRITE, ch, SEL_CTRL, data, 1'b0);
        n_ticks = $urandom_range(1, 24);
        for (int k = 0; k < n_ticks; k++) begin
            case ($urandom_range(0, 9))
                6: queue_access(OP_READ, 2'($urandom_range(0, 3)),
                                3'($urandom_range(0, 4)), $urandom, 1'b0);
                7: queue_access(OP_WRITE, 2'($urandom_range(0, 3)), SEL_FLAG,
                                $urandom, 1'b0);
                8: queue_access(OP_WRITE, 2'($urandom_range(0, 3)), SEL_LOAD,
                                32'($urandom_range(0, 7)), 1'b0);
                9: queue_noise(1'b0);
                default: queue_access(OP_TICK, 2'($urandom_range(0, 3)),
                                      3'($urandom_range(0, 7)), $urandom, 1'b0);
            endcase
        end
    endtask

    initial begin
        for (int c = 0; c < NUM_CH; c++) begin
            chan_load[c]   = '0;
            chan_count[c]  = '0;
            chan_enable[c] = 1'b0;
            chan_irq_en[c] = 1'b0;
            chan_flag[c]   = 1'b0;
        end
        module_off = 1'b1;

        // Directed part: reset state, a full period, register corner cases.
        queue_access(OP_READ,  2'd0, SEL_MODULE, 32'h0000_0000, 1'b0);
        queue_access(OP_TICK,  2'd0, SEL_LOAD,   32'h0000_0000, 1'b0);
        queue_access(OP_WRITE, 2'd0, SEL_LOAD,   32'h0000_0003, 1'b0);
        queue_access(OP_WRITE, 2'd0, SEL_CTRL,   32'h0000_0003, 1'b0);
        queue_access(OP_TICK,  2'd0, SEL_LOAD,   32'h0000_0000, 1'b0);
        queue_access(OP_WRITE, 2'd3, SEL_MODULE, 32'h0000_0000, 1'b0);
        repeat (4) queue_access(OP_TICK, 2'd0, SEL_LOAD, 32'h0000_0000, 1'b0);
        queue_access(OP_READ,  2'd0, SEL_FLAG,   32'h0000_0000, 1'b0);
        queue_access(OP_WRITE, 2'd0, SEL_COUNT,  32'hFFFF_FFFF, 1'b0);
        queue_access(OP_READ,  2'd0, SEL_COUNT,  32'h0000_0000, 1'b0);
        queue_access(OP_WRITE, 2'd0, SEL_LOAD,   32'hFFFF_FFFF, 1'b0);
        queue_access(OP_WRITE, 2'd0, SEL_CTRL,   32'h0000_0003, 1'b0);
        queue_access(OP_READ,  2'd0, SEL_COUNT,  32'h0000_0000, 1'b0);
        queue_access(OP_WRITE, 2'd0, SEL_FLAG,   32'hFFFF_FFFE, 1'b0);
        queue_access(OP_WRITE, 2'd0, SEL_FLAG,   32'h0000_0001, 1'b0);
        queue_access(OP_NONE,  2'd3, SEL_SPARE_HI, 32'hFFFF_FFFF, 1'b0);
        queue_access(OP_READ,  2'd3, SEL_SPARE_HI, 32'hFFFF_FFFF, 1'b0);
        queue_access(OP_WRITE, 2'd3, SEL_SPARE_LO, 32'hFFFF_FFFF, 1'b0);
        queue_access(OP_WRITE, 2'd3, SEL_CTRL,   32'h0000_0002, 1'b0);
        queue_access(OP_READ,  2'd3, SEL_CTRL,   32'h0000_0000, 1'b0);
        queue_access(OP_READ,  2'd0, SEL_LOAD,   32'h0000_0000, 1'b0);
        queue_access(OP_WRITE, 2'd3, SEL_MODULE, 32'hFFFF_FFFF, 1'b0);
        queue_access(OP_READ,  2'd2, SEL_MODULE, 32'hFFFF_FFFF, 1'b1);

        while (queued_accesses.size() < RANDOM_ITEMS) begin
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 6)) queue_noise($urandom_range(0, 49) == 0);
            end else begin
                queue_timer_sequence();
            end
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(negedge i_clk);
        while (queued_accesses.size() != 0 || i_in_valid || pending_timer_results.size() != 0);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (pending_timer_results.size() != 0) begin
            error_count++;
            $display("ERROR: %0d expected results never arrived", pending_timer_results.size());
        end
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                pending_timer_results.push_back(predict_timer_step(i_in_item));
                void'(queued_accesses.pop_front());
                sent_count++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (queued_accesses.size() == 0 ||
                             (queued_accesses[0].hold && sent_count != recv_count)) begin
                    i_in_valid <= 1'b0;
                end else begin
                    i_in_valid <= 1'b1;
                    i_in_item  <= queued_accesses[0].item;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
        end
    end

    t_stall_mode stall_mode  = STALL_NONE;
    int          mode_left   = 0;
    int          stall_cycle = 0;

    always @(posedge i_clk) begin
        t_out_item expected;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                recv_count <= recv_count + 1;
                if (pending_timer_results.size() == 0) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS) begin
                        $display("ERROR: unexpected result read_data %h irq %h flag %h",
                                 o_out_item.read_data, o_out_item.irq_lines,
                                 o_out_item.flag_bits);
                    end
                end else begin
                    expected = pending_timer_results.pop_front();
                    if (o_out_item.read_data !== expected.read_data ||
                        o_out_item.irq_lines !== expected.irq_lines ||
                        o_out_item.flag_bits !== expected.flag_bits) begin
                        error_count++;
                        if (error_count <= MAX_REPORTS) begin
                            $display({"ERROR: result %0d: read_data exp %h got %h, ",
                                      "irq exp %h got %h, flag exp %h got %h"},
                                     recv_count, expected.read_data, o_out_item.read_data,
                                     expected.irq_lines, o_out_item.irq_lines,
                                     expected.flag_bits, o_out_item.flag_bits);
                        end
                    end
                end
            end
            if (mode_left == 0) begin
                stall_mode = t_stall_mode'($urandom_range(0, 3));
                mode_left  = $urandom_range(20, 200);
            end else begin
                mode_left--;
            end
            stall_cycle++;
            case (stall_mode)
                STALL_LIGHT:    i_out_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY:    i_out_stall <= ($urandom_range(0, 9) < 7);
                STALL_PERIODIC: i_out_stall <= (stall_cycle % 4 != 0);
                default:        i_out_stall <= 1'b0;
            endcase
        end
    end

    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("ERROR: no transaction for %0d cycles", idle_cycles);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

endmodule
